### design/pmc_pkg.sv
// Shared types and constants for the PWM input capture meter.
`timescale 1ns / 1ps
package pmc_pkg;

	// Field widths of the result beat, the prescaler and the configuration port
	localparam int CAPT_W  = 16;
	localparam int DUTY_W  = 7;
	localparam int FREQ_W  = 20;
	localparam int PRESC_W = 16;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELOAD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NUMER    = 2'd3;

	// Reset values of the registers
	localparam logic [PRESC_W-1:0] PRESCALE_RST = 16'd640;
	localparam logic [CAPT_W-1:0]  RELOAD_RST   = 16'hffff;
	localparam logic [FREQ_W-1:0]  NUMER_RST    = 20'd50000;

	// Arithmetic constants
	localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;
	localparam logic [FREQ_W-1:0] US_PER_S   = 20'd1000000;

	// Divider operand selection
	localparam logic [1:0] SEL_DUTY  = 2'd0;
	localparam logic [1:0] SEL_FREQ  = 2'd1;
	localparam logic [1:0] SEL_PERUS = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic       in_ready;
		logic       div_start;
		logic [1:0] div_sel;
		logic       st_duty;
		logic       st_freq;
		logic       st_perus;
		logic       out_load;
	} pmc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic result_due;
		logic div_done;
		logic freq_is_zero;
		logic out_full;
	} pmc_status_t;

endpackage

### design/pmc_if.sv
// Valid/ready channel interfaces for the sample and result streams.
`timescale 1ns / 1ps
interface pmc_sample_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface pmc_result_if;
	logic                        valid;
	logic                        ready;
	logic [pmc_pkg::CAPT_W-1:0]  period_count;
	logic [pmc_pkg::CAPT_W-1:0]  high_count;
	logic [pmc_pkg::DUTY_W-1:0]  duty_percent;
	logic [pmc_pkg::FREQ_W-1:0]  freq_hz;
	logic [pmc_pkg::FREQ_W-1:0]  period_us;
	logic                        freq_zero;

	modport source (output valid, output period_count, output high_count,
		output duty_percent, output freq_hz, output period_us, output freq_zero,
		input ready);
	modport sink (input valid, input period_count, input high_count,
		input duty_percent, input freq_hz, input period_us, input freq_zero,
		output ready);
endinterface

### design/pmc_ctrl.sv
// Sequencer for the capture arithmetic: duty, frequency, period (skipped at zero frequency), then output.
`timescale 1ns / 1ps
module pmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  pmc_pkg::pmc_status_t st,
	output pmc_pkg::pmc_cmd_t    cmd
);
	import pmc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DUTY  = 3'd1;
	localparam logic [2:0] S_FREQ  = 3'd2;
	localparam logic [2:0] S_PERUS = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_sel = SEL_DUTY;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.result_due) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = SEL_DUTY;
					state_d = S_DUTY;
				end
			end
			S_DUTY: begin
				if (st.div_done) begin
					cmd.st_duty = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel = SEL_FREQ;
					state_d = S_FREQ;
				end
			end
			S_FREQ: begin
				if (st.div_done) begin
					cmd.st_freq = 1'b1;
					if (st.freq_is_zero) begin
						state_d = S_OUT;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel = SEL_PERUS;
						state_d = S_PERUS;
					end
				end
			end
			S_PERUS: begin
				if (st.div_done) begin
					cmd.st_perus = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!st.out_full) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### design/pmc_datapath.sv
// Timer, edge capture, shared restoring divider and output register.
`timescale 1ns / 1ps
module pmc_datapath #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pmc_pkg::CFG_W-1:0]       cfg_data,
	pmc_sample_if.sink                      sample,
	pmc_result_if.source                    result,
	input  pmc_pkg::pmc_cmd_t               cmd,
	output pmc_pkg::pmc_status_t            st
);
	import pmc_pkg::*;

	localparam int PROD_W = COUNTER_BITS + DUTY_W;
	localparam int DIV_W  = (PROD_W > FREQ_W) ? PROD_W : FREQ_W;
	localparam int STEP_W = $clog2(DIV_W);

	// Configuration registers
	logic [PRESC_W-1:0]      prescale_limit_q;
	logic [CAPT_W-1:0]       reload_value_q;
	logic                    capture_enable_q;
	logic [FREQ_W-1:0]       freq_numerator_q;

	// Timer state
	logic [PRESC_W-1:0]      prescale_q;
	logic [COUNTER_BITS-1:0] counter_q;
	logic                    last_level_q;
	logic [COUNTER_BITS-1:0] high_capture_q;
	logic [COUNTER_BITS-1:0] period_q;

	// Divider
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        quo_q;
	logic [DIV_W-1:0]        divisor_q;
	logic [STEP_W-1:0]       step_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIV_W:0]          div_shift;
	logic [DIV_W:0]          div_trial;
	logic [DIV_W-1:0]        op_dividend;
	logic [DIV_W-1:0]        op_divisor;
	logic [PROD_W-1:0]       duty_prod;

	// Results
	logic [DUTY_W-1:0]       duty_q;
	logic [FREQ_W-1:0]       freq_q;
	logic [FREQ_W-1:0]       perus_q;
	logic                    fz_q;

	logic in_fire;
	logic rising;
	logic falling;

	assign sample.ready = cmd.in_ready;
	assign in_fire = sample.valid && cmd.in_ready;
	assign rising  = sample.pin_level && !last_level_q;
	assign falling = !sample.pin_level && last_level_q;

	assign st.result_due   = in_fire && capture_enable_q && rising && (counter_q != '0);
	assign st.div_done     = done_q;
	assign st.freq_is_zero = (quo_q == '0);
	assign st.out_full     = result.valid && !result.ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_limit_q <= PRESCALE_RST;
			reload_value_q   <= RELOAD_RST;
			capture_enable_q <= 1'b0;
			freq_numerator_q <= NUMER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESCALE: prescale_limit_q <= cfg_data[PRESC_W-1:0];
				REG_RELOAD:   reload_value_q   <= cfg_data[CAPT_W-1:0];
				REG_ENABLE:   capture_enable_q <= cfg_data[0];
				REG_NUMER:    freq_numerator_q <= cfg_data[FREQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Prescaler, counter, edge detect and captures, one beat per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q     <= '0;
			counter_q      <= '0;
			last_level_q   <= 1'b0;
			high_capture_q <= '0;
		end else if (in_fire) begin
			last_level_q <= sample.pin_level;
			if (capture_enable_q) begin
				if (rising) begin
					counter_q  <= '0;
					prescale_q <= '0;
				end else begin
					if (falling) begin
						high_capture_q <= counter_q;
					end
					if (prescale_q >= prescale_limit_q) begin
						prescale_q <= '0;
						if ({{(CAPT_W){1'b0}}, counter_q} >=
							{{(COUNTER_BITS){1'b0}}, reload_value_q}) begin
							counter_q <= '0;
						end else begin
							counter_q <= counter_q + 1'b1;
						end
					end else begin
						prescale_q <= prescale_q + 1'b1;
					end
				end
			end
		end
	end

	// Period capture at the edge that starts the arithmetic
	always_ff @(posedge clk) begin
		if (st.result_due) begin
			period_q <= counter_q;
		end
	end

	// Divider operand selection
	assign duty_prod = {{(DUTY_W){1'b0}}, high_capture_q} * PROD_W'(DUTY_SCALE);

	always_comb begin
		case (cmd.div_sel)
			SEL_DUTY: begin
				op_dividend = DIV_W'(duty_prod);
				op_divisor  = DIV_W'(counter_q);
			end
			SEL_FREQ: begin
				op_dividend = DIV_W'(freq_numerator_q);
				op_divisor  = DIV_W'(period_q);
			end
			SEL_PERUS: begin
				op_dividend = DIV_W'(US_PER_S);
				op_divisor  = DIV_W'(quo_q[FREQ_W-1:0]);
			end
			default: begin
				op_dividend = '0;
				op_divisor  = '0;
			end
		endcase
	end

	// Restoring division, one quotient bit per cycle
	assign div_shift = {rem_q, quo_q[DIV_W-1]};
	assign div_trial = div_shift - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (cmd.div_start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q     <= '0;
			quo_q     <= op_dividend;
			divisor_q <= op_divisor;
		end else if (busy_q) begin
			if (!div_trial[DIV_W]) begin
				rem_q <= div_trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= div_shift[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// Result holding registers
	always_ff @(posedge clk) begin
		if (cmd.st_duty) begin
			duty_q <= (quo_q > DIV_W'(DUTY_SCALE)) ? DUTY_SCALE : quo_q[DUTY_W-1:0];
		end
		if (cmd.st_freq) begin
			freq_q  <= quo_q[FREQ_W-1:0];
			fz_q    <= (quo_q == '0);
			perus_q <= US_PER_S;
		end
		if (cmd.st_perus) begin
			perus_q <= quo_q[FREQ_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (cmd.out_load) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.period_count <= CAPT_W'(period_q);
			result.high_count   <= CAPT_W'(high_capture_q);
			result.duty_percent <= duty_q;
			result.freq_hz      <= freq_q;
			result.period_us    <= perus_q;
			result.freq_zero    <= fz_q;
		end
	end
endmodule

### design/pwm_input_capture_meter.sv
// PWM input capture meter: one pin sample per beat, one result per measured period.
// A sample that closes no period is taken back to back while the sequencer is idle.
// A rising edge that closes a nonzero period runs three divisions (two at zero frequency) on one
// shared restoring divider, one bit per cycle, each giving a max(COUNTER_BITS+7, 20)-bit quotient,
// so samples are held off until the result is loaded into the output register.
// Reset clears the timer, the high-time capture and the valid flag; registers take defaults.
`timescale 1ns / 1ps
module pwm_input_capture_meter #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pmc_pkg::CFG_W-1:0]     cfg_data,
	pmc_sample_if.sink                    sample,
	pmc_result_if.source                  result
);
	import pmc_pkg::*;

	pmc_cmd_t    cmd;
	pmc_status_t st;

	// Sequencer
	pmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// Timer and arithmetic
	pmc_datapath #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.result    (result),
		.cmd       (cmd),
		.st        (st)
	);
endmodule

### design/pmc_checker.sv
// Port-level checks on the result stream of the capture meter.
`timescale 1ns / 1ps
module pmc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [pmc_pkg::DUTY_W-1:0]   duty_percent,
	input logic [pmc_pkg::FREQ_W-1:0]   freq_hz,
	input logic [pmc_pkg::FREQ_W-1:0]   period_us,
	input logic                         freq_zero
);
	import pmc_pkg::*;

	// A stalled result beat holds its valid flag, frequency and period
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(freq_hz) && $stable(period_us))
		else $error("result beat changed while stalled");

	// Duty is saturated
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_percent <= DUTY_SCALE)
		else $error("duty above 100 percent");

	// Zero flag matches the frequency
	a_fz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (freq_zero == (freq_hz == '0)))
		else $error("freq_zero disagrees with freq_hz");

	// Zero frequency saturates the period
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && freq_zero |-> period_us == US_PER_S)
		else $error("period not saturated at zero frequency");
endmodule

bind pwm_input_capture_meter pmc_checker u_pmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.duty_percent (result.duty_percent),
	.freq_hz      (result.freq_hz),
	.period_us    (result.period_us),
	.freq_zero    (result.freq_zero)
);
